### rtl/swr_pkg.sv
// Package with the item types and status codes of the square window rotator.
package swr_pkg;

    localparam int CELL_W = 17;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_WIN_ERR = 2'd1;
    localparam logic [1:0] ST_RD_ERR  = 2'd2;

    localparam logic REQ_ROTATE = 1'b0;
    localparam logic REQ_READ   = 1'b1;

    localparam logic DIR_CW = 1'b0;

    typedef struct packed {
        logic       req_type;
        logic [8:0] center_row;
        logic [8:0] center_col;
        logic [6:0] radius;
        logic       direction;
        logic [8:0] read_row;
        logic [8:0] read_col;
    } swr_req_t;

    typedef struct packed {
        logic [CELL_W-1:0] cell_value;
        logic [1:0]        status;
    } swr_res_t;

endpackage

### rtl/swr_seq.sv
// Sequencer that fills, copies and rewrites the grid through the two memories.
module swr_seq #(
    parameter int MAX_SIDE = 256
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  swr_pkg::swr_req_t        req,
    output logic                     done,
    output swr_pkg::swr_res_t        result,
    input  logic                     cfg_we,
    input  logic [8:0]               cfg_data,
    output logic                     grid_we,
    output logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0] grid_waddr,
    output logic [swr_pkg::CELL_W-1:0] grid_wdata,
    output logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0] grid_raddr,
    input  logic [swr_pkg::CELL_W-1:0] grid_rdata,
    output logic                     copy_we,
    output logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0] copy_waddr,
    output logic [swr_pkg::CELL_W-1:0] copy_wdata,
    output logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0] copy_raddr,
    input  logic [swr_pkg::CELL_W-1:0] copy_rdata
);
    import swr_pkg::*;

    localparam int AW = $clog2(MAX_SIDE * MAX_SIDE);
    localparam int IW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int SW = $clog2(MAX_SIDE + 1);
    localparam int CW = 12;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FILL  = 3'd1;
    localparam logic [2:0] S_COPY  = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_WB    = 3'd4;
    localparam logic [2:0] S_RD    = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;

    logic [2:0]        state_reg, state_next;
    logic [SW-1:0]     side_reg, side_next;
    logic [IW-1:0]     fr_reg, fr_next, fc_reg, fc_next;
    logic [CELL_W-1:0] cnt_reg, cnt_next;
    logic [7:0]        a_reg, a_next, b_reg, b_next, s1_reg, s1_next;
    logic [IW-1:0]     top_reg, top_next, left_reg, left_next;
    logic              dir_reg, dir_next;
    logic              pv_reg, pv_next;
    logic [AW-1:0]     pa_reg, pa_next;
    logic              isread_reg, isread_next;
    logic [1:0]        status_reg, status_next;
    logic [AW-1:0]     raddr_reg, raddr_next;

    logic [CW-1:0] side_w, cr_w, cc_w, rad_w, rr_w, rc_w, sat_w;
    logic          win_ok, rd_ok, fill_in;
    logic [7:0]    src_a, src_b;
    logic [AW-1:0] cur_addr, src_addr, fill_addr;

    function automatic logic [AW-1:0] addr_of(input logic [IW-1:0] row,
                                              input logic [IW-1:0] col);
        addr_of = AW'(AW'(row) * AW'(MAX_SIDE)) + AW'(col);
    endfunction

    always_comb
    begin
        side_w = CW'(side_reg);
        cr_w   = CW'(req.center_row);
        cc_w   = CW'(req.center_col);
        rad_w  = CW'(req.radius);
        rr_w   = CW'(req.read_row);
        rc_w   = CW'(req.read_col);
        sat_w  = CW'(cfg_data);
        if (sat_w == '0)
        begin
            sat_w = CW'(1);
        end
        if (sat_w > CW'(MAX_SIDE))
        begin
            sat_w = CW'(MAX_SIDE);
        end
        win_ok = (cr_w >= rad_w + CW'(1)) && (cr_w + rad_w <= side_w) &&
                 (cc_w >= rad_w + CW'(1)) && (cc_w + rad_w <= side_w);
        rd_ok  = (rr_w >= CW'(1)) && (rr_w <= side_w) &&
                 (rc_w >= CW'(1)) && (rc_w <= side_w);
        fill_in = (CW'(fr_reg) < side_w) && (CW'(fc_reg) < side_w);
        if (dir_reg == DIR_CW)
        begin
            src_a = s1_reg - b_reg;
            src_b = a_reg;
        end
        else
        begin
            src_a = b_reg;
            src_b = s1_reg - a_reg;
        end
        cur_addr  = addr_of(top_reg + IW'(a_reg), left_reg + IW'(b_reg));
        src_addr  = addr_of(top_reg + IW'(src_a), left_reg + IW'(src_b));
        fill_addr = addr_of(fr_reg, fc_reg);
    end

    always_comb
    begin
        state_next  = state_reg;
        side_next   = side_reg;
        fr_next     = fr_reg;
        fc_next     = fc_reg;
        cnt_next    = cnt_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        s1_next     = s1_reg;
        top_next    = top_reg;
        left_next   = left_reg;
        dir_next    = dir_reg;
        pv_next     = 1'b0;
        pa_next     = cur_addr;
        isread_next = isread_reg;
        status_next = status_reg;
        raddr_next  = raddr_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    isread_next = (req.req_type == REQ_READ);
                    if (req.req_type == REQ_READ)
                    begin
                        raddr_next = addr_of(IW'(rr_w - CW'(1)), IW'(rc_w - CW'(1)));
                        status_next = rd_ok ? ST_OK : ST_RD_ERR;
                        state_next  = rd_ok ? S_RD : S_FIN;
                    end
                    else
                    begin
                        status_next = win_ok ? ST_OK : ST_WIN_ERR;
                        state_next  = win_ok ? S_COPY : S_FIN;
                        top_next    = IW'(cr_w - CW'(1) - rad_w);
                        left_next   = IW'(cc_w - CW'(1) - rad_w);
                        s1_next     = {req.radius, 1'b0};
                        dir_next    = req.direction;
                        a_next      = '0;
                        b_next      = '0;
                    end
                end
            end
            S_FILL:
            begin
                if (fill_in)
                begin
                    cnt_next = cnt_reg + CELL_W'(1);
                end
                if (fc_reg == IW'(MAX_SIDE - 1))
                begin
                    fc_next = '0;
                    fr_next = fr_reg + IW'(1);
                    if (fr_reg == IW'(MAX_SIDE - 1))
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    fc_next = fc_reg + IW'(1);
                end
            end
            S_COPY, S_WB:
            begin
                pv_next = 1'b1;
                if (b_reg == s1_reg)
                begin
                    b_next = '0;
                    a_next = a_reg + 8'd1;
                    if (a_reg == s1_reg)
                    begin
                        a_next     = '0;
                        state_next = (state_reg == S_COPY) ? S_DRAIN : S_FIN;
                    end
                end
                else
                begin
                    b_next = b_reg + 8'd1;
                end
            end
            S_DRAIN: state_next = S_WB;
            S_RD:    state_next = S_FIN;
            S_FIN:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
        if (cfg_we)
        begin
            side_next  = SW'(sat_w);
            state_next = S_FILL;
            fr_next    = '0;
            fc_next    = '0;
            cnt_next   = CELL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_FILL;
            side_reg   <= SW'(MAX_SIDE);
            fr_reg     <= '0;
            fc_reg     <= '0;
            cnt_reg    <= CELL_W'(1);
            a_reg      <= '0;
            b_reg      <= '0;
            pv_reg     <= 1'b0;
            isread_reg <= 1'b0;
            status_reg <= ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            side_reg   <= side_next;
            fr_reg     <= fr_next;
            fc_reg     <= fc_next;
            cnt_reg    <= cnt_next;
            a_reg      <= a_next;
            b_reg      <= b_next;
            pv_reg     <= pv_next;
            isread_reg <= isread_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg    <= s1_next;
        top_reg   <= top_next;
        left_reg  <= left_next;
        dir_reg   <= dir_next;
        pa_reg    <= pa_next;
        raddr_reg <= raddr_next;
    end

    always_comb
    begin
        busy       = (state_reg != S_IDLE);
        done       = (state_reg == S_FIN);
        result.status     = status_reg;
        result.cell_value = (isread_reg && status_reg == ST_OK) ? grid_rdata : '0;
        grid_raddr = (state_reg == S_RD) ? raddr_reg : cur_addr;
        copy_raddr = src_addr;
        copy_we    = pv_reg && (state_reg == S_COPY || state_reg == S_DRAIN);
        copy_waddr = pa_reg;
        copy_wdata = grid_rdata;
        if (state_reg == S_FILL)
        begin
            grid_we    = 1'b1;
            grid_waddr = fill_addr;
            grid_wdata = fill_in ? cnt_reg : '0;
        end
        else
        begin
            grid_we    = pv_reg && (state_reg == S_WB || state_reg == S_FIN);
            grid_waddr = pa_reg;
            grid_wdata = copy_rdata;
        end
    end

endmodule

### rtl/square_window_rotator_top.sv
// Top level of the square window rotator: grid and scratch memories plus sequencer.
// A read passes through S_RD to done and a flagged request goes straight to done. A
// rotate of side s = 2*radius+1 makes one memory access per cell to copy the window
// out and one per cell to write it back turned. After reset and after every
// side_length write the grid is refilled, one cell per cycle, over all
// MAX_SIDE*MAX_SIDE cells with busy high. The result is shown for one cycle with
// done and must be taken then; the receiver cannot stall it.
module square_window_rotator_top #(
    parameter int MAX_SIDE = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  swr_pkg::swr_req_t req,
    output logic              done,
    output swr_pkg::swr_res_t result,
    input  logic              cfg_we,
    input  logic [8:0]        cfg_data
);
    import swr_pkg::*;

    localparam int AW    = $clog2(MAX_SIDE * MAX_SIDE);
    localparam int CELLS = MAX_SIDE * MAX_SIDE;

    logic              grid_we, copy_we;
    logic [AW-1:0]     grid_waddr, grid_raddr, copy_waddr, copy_raddr;
    logic [CELL_W-1:0] grid_wdata, copy_wdata;
    logic [CELL_W-1:0] grid_rdata_reg, copy_rdata_reg;
    logic [CELL_W-1:0] grid_mem [CELLS];
    logic [CELL_W-1:0] copy_mem [CELLS];

    swr_seq #(.MAX_SIDE(MAX_SIDE)) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req        (req),
        .done       (done),
        .result     (result),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .grid_we    (grid_we),
        .grid_waddr (grid_waddr),
        .grid_wdata (grid_wdata),
        .grid_raddr (grid_raddr),
        .grid_rdata (grid_rdata_reg),
        .copy_we    (copy_we),
        .copy_waddr (copy_waddr),
        .copy_wdata (copy_wdata),
        .copy_raddr (copy_raddr),
        .copy_rdata (copy_rdata_reg)
    );

    always_ff @(posedge clk)
    begin
        if (grid_we)
        begin
            grid_mem[grid_waddr] <= grid_wdata;
        end
        grid_rdata_reg <= grid_mem[grid_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (copy_we)
        begin
            copy_mem[copy_waddr] <= copy_wdata;
        end
        copy_rdata_reg <= copy_mem[copy_raddr];
    end

    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after an accepted item");

    a_done_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("done outside a busy period");

    a_one_memory_written: assert property (@(posedge clk) disable iff (!rst_n)
        !(grid_we && copy_we))
        else $error("both memories written in one cycle");

    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> !(grid_we || copy_we))
        else $error("memory written while idle");

endmodule

### tb/sv/square_window_rotator_top_tb.sv
// Testbench for the square window rotator: directed and random requests checked against a grid model.
`timescale 1ns / 100ps

module square_window_rotator_top_tb;

    import swr_pkg::*;

    localparam int MAX_SIDE   = 256;
    localparam int CELLS      = MAX_SIDE * MAX_SIDE;
    localparam int CYCLE_CAP  = 4000000;
    localparam int MAX_REPORT = 10;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     start = 1'b0;
    logic     busy;
    swr_req_t req = '0;
    logic     done;
    swr_res_t result;
    logic     cfg_we = 1'b0;
    logic [8:0] cfg_data = '0;

    logic [CELL_W-1:0] grid_cells [CELLS];
    logic [CELL_W-1:0] window_cells [CELLS];
    int unsigned       active_side;
    swr_res_t          pending_results [$];
    int unsigned       mismatch_count = 0;
    int unsigned       cycle_count = 0;

    square_window_rotator_top #(.MAX_SIDE(MAX_SIDE)) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .req      (req),
        .done     (done),
        .result   (result),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic int cell_index(int unsigned row, int unsigned col);
        return ((row - 1) * MAX_SIDE + (col - 1)) % CELLS;
    endfunction

    function automatic void refill_grid();
        int unsigned count;
        count = 0;
        for (int i = 0; i < CELLS; i++)
            grid_cells[i] = '0;
        for (int r = 1; r <= active_side; r++)
            for (int c = 1; c <= active_side; c++)
            begin
                count++;
                grid_cells[cell_index(r, c)] = count[CELL_W-1:0];
            end
    endfunction

    function automatic bit span_fits(int unsigned center, int unsigned rad);
        return center >= rad + 1 && center + rad <= active_side;
    endfunction

    function automatic swr_res_t predict_request(swr_req_t item);
        swr_res_t    res;
        int unsigned top, left, s, sa, sb;
        res = '0;
        if (item.req_type == REQ_ROTATE)
        begin
            if (span_fits(item.center_row, item.radius) && span_fits(item.center_col, item.radius))
            begin
                top  = item.center_row - item.radius;
                left = item.center_col - item.radius;
                s    = 2 * item.radius + 1;
                for (int a = 0; a < s; a++)
                    for (int b = 0; b < s; b++)
                        window_cells[cell_index(top + a, left + b)] =
                            grid_cells[cell_index(top + a, left + b)];
                for (int a = 0; a < s; a++)
                    for (int b = 0; b < s; b++)
                    begin
                        if (item.direction == DIR_CW)
                        begin
                            sa = s - 1 - b;
                            sb = a;
                        end
                        else
                        begin
                            sa = b;
                            sb = s - 1 - a;
                        end
                        grid_cells[cell_index(top + a, left + b)] =
                            window_cells[cell_index(top + sa, left + sb)];
                    end
            end
            else
                res.status = ST_WIN_ERR;
        end
        else if (item.read_row >= 1 && item.read_row <= active_side &&
                 item.read_col >= 1 && item.read_col <= active_side)
            res.cell_value = grid_cells[cell_index(item.read_row, item.read_col)];
        else
            res.status = ST_RD_ERR;
        return res;
    endfunction

    always @(negedge clk)
    begin
        swr_res_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORT)
                    $display("Unexpected result: value %0d status %0d",
                             result.cell_value, result.status);
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.cell_value !== want.cell_value || result.status !== want.status)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORT)
                        $display("Result mismatch: expected value %0d status %0d, got value %0d status %0d",
                                 want.cell_value, want.status, result.cell_value, result.status);
                end
            end
        end
    end

    task automatic send_item(swr_req_t item, bit allow_gap = 1'b1);
        int gap;
        gap = allow_gap ? $urandom_range(0, 12) : 0;
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        req   <= item;
        forever
        begin
            @(negedge clk);
            if (!busy)
                break;
        end
        @(posedge clk);
        pending_results.push_back(predict_request(item));
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_side(logic [8:0] value);
        int unsigned v;
        drain_results();
        forever
        begin
            @(negedge clk);
            if (!busy)
                break;
        end
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        v = value;
        if (v < 1)
            v = 1;
        if (v > MAX_SIDE)
            v = MAX_SIDE;
        active_side = v;
        refill_grid();
        repeat (4) @(posedge clk);
    endtask

    function automatic swr_req_t rotate_req(int unsigned row, int unsigned col,
                                            int unsigned rad, bit dir);
        swr_req_t item;
        item            = '0;
        item.req_type   = REQ_ROTATE;
        item.center_row = 9'(row);
        item.center_col = 9'(col);
        item.radius     = 7'(rad);
        item.direction  = dir;
        item.read_row   = 9'($urandom);
        item.read_col   = 9'($urandom);
        return item;
    endfunction

    function automatic swr_req_t read_req(int unsigned row, int unsigned col);
        swr_req_t item;
        item            = '0;
        item.req_type   = REQ_READ;
        item.center_row = 9'($urandom);
        item.center_col = 9'($urandom);
        item.radius     = 7'($urandom);
        item.direction  = 1'($urandom);
        item.read_row   = 9'(row);
        item.read_col   = 9'(col);
        return item;
    endfunction

    function automatic swr_req_t noise_req();
        swr_req_t item;
        item.req_type   = 1'($urandom);
        item.center_row = 9'($urandom);
        item.center_col = 9'($urandom);
        item.radius     = 7'($urandom);
        item.direction  = 1'($urandom);
        item.read_row   = 9'($urandom);
        item.read_col   = 9'($urandom);
        return item;
    endfunction

    task automatic test_reset_contents();
        send_item(read_req(1, 1));
        send_item(read_req(1, 256));
        send_item(read_req(256, 1));
        send_item(read_req(256, 256));
        send_item(read_req(0, 5));
        send_item(read_req(5, 257));
        send_item(read_req(511, 511));
    endtask

    task automatic test_directed_rotates();
        send_item(rotate_req(10, 10, 0, 1'b0));
        send_item(rotate_req(2, 2, 1, 1'b0), 1'b0);
        send_item(read_req(1, 1), 1'b0);
        send_item(read_req(1, 3));
        send_item(rotate_req(2, 2, 1, 1'b1));
        send_item(rotate_req(2, 2, 1, 1'b1));
        send_item(read_req(3, 1));
        send_item(rotate_req(1, 5, 1, 1'b0));
        send_item(rotate_req(5, 256, 1, 1'b0));
        send_item(rotate_req(0, 0, 0, 1'b1));
        send_item(rotate_req(511, 511, 127, 1'b1));
        send_item(rotate_req(128, 128, 127, 1'b0));
        send_item(read_req(1, 1));
        send_item(read_req(255, 255));
        send_item(read_req(256, 256));
    endtask

    task automatic test_side_extremes();
        write_side(9'd0);
        send_item(read_req(1, 1));
        send_item(read_req(1, 2));
        send_item(rotate_req(1, 1, 0, 1'b1));
        send_item(rotate_req(1, 1, 1, 1'b0));
        write_side(9'd511);
        send_item(read_req(256, 256));
        send_item(read_req(100, 3));
    endtask

    task automatic test_random_traffic(logic [8:0] side, int count);
        int unsigned pick, rad, max_rad;
        write_side(side);
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                max_rad = (active_side - 1) / 2;
                if (max_rad > 5)
                    max_rad = 5;
                rad = $urandom_range(0, max_rad);
                send_item(rotate_req($urandom_range(rad + 1, active_side - rad),
                                     $urandom_range(rad + 1, active_side - rad),
                                     rad, 1'($urandom)));
            end
            else if (pick < 80)
                send_item(read_req($urandom_range(1, active_side),
                                   $urandom_range(1, active_side)));
            else if (pick < 90)
                send_item(rotate_req($urandom_range(0, active_side + 2),
                                     $urandom_range(0, active_side + 2),
                                     $urandom_range(0, 6), 1'($urandom)));
            else
            begin
                send_item(noise_req());
                if ($urandom_range(0, 1) == 0)
                begin
                    start <= 1'b0;
                    repeat ($urandom_range(20, 60)) @(posedge clk);
                end
            end
        end
    endtask

    initial
    begin
        active_side = MAX_SIDE;
        refill_grid();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_contents();
        test_directed_rotates();
        test_side_extremes();
        test_random_traffic(9'd12, 190);
        test_random_traffic(9'd7, 100);
        drain_results();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
